### src/q2e_pkg.sv
// q2e_pkg: widths, constants, types and the CORDIC arctangent table for the
// quaternion to Euler angle pipeline. No dependencies.
`default_nettype none

package q2e_pkg;

  // field and datapath widths
  localparam int QUAT_W   = 16;
  localparam int ANG_W    = 16;
  localparam int PROD_W   = 32;
  localparam int SUM_W    = 34;
  localparam int MAG_W    = 28;
  localparam int REM_W    = 58;
  localparam int ROOT_W   = 29;
  localparam int XY_W     = 37;
  localparam int Z_W      = 32;
  localparam int DEG_W    = 29;
  localparam int SCL_W    = 61;
  localparam int RND_SH   = 44;
  localparam int RAD_SH   = 28;

  // pipeline lengths of the fixed sections
  localparam int FRONT_LAT = 3;
  localparam int ISQ_LAT   = 29;
  localparam int SCALE_LAT = 2;
  localparam int REM_TOP   = 56;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;

  localparam logic signed [SUM_W-1:0] ONE_Q28     = 34'sd268435456;
  localparam logic signed [Z_W-1:0]   HALF_PI_Q28 = 32'sd421657428;
  // degrees*64 per radian at scale 2^16
  localparam logic signed [DEG_W-1:0] DEG64_Q16   = 29'sd240315917;

  typedef enum logic {
    UNIT_RAD = 1'b0,
    UNIT_DEG = 1'b1
  } unit_t;

  // product sums that travel alongside the square root
  typedef struct packed {
    logic signed [SUM_W-1:0] sr;
    logic signed [SUM_W-1:0] cr;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] cy;
    logic signed [SUM_W-1:0] sp;
    logic                    clp;
    logic                    cln;
  } front_t;

  // atan(2^-i) in radians at scale 2^28
  function automatic logic signed [Z_W-1:0] atan_q28(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:  v = 32'sd210828714;
      1:  v = 32'sd124459457;
      2:  v = 32'sd65760959;
      3:  v = 32'sd33381290;
      4:  v = 32'sd16755422;
      5:  v = 32'sd8385879;
      6:  v = 32'sd4193963;
      7:  v = 32'sd2097109;
      8:  v = 32'sd1048571;
      9:  v = 32'sd524287;
      10: v = 32'sd262144;
      11: v = 32'sd131072;
      12: v = 32'sd65536;
      13: v = 32'sd32768;
      14: v = 32'sd16384;
      15: v = 32'sd8192;
      16: v = 32'sd4096;
      17: v = 32'sd2048;
      18: v = 32'sd1024;
      19: v = 32'sd512;
      20: v = 32'sd256;
      21: v = 32'sd128;
      22: v = 32'sd64;
      default: v = 32'sd32;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### src/q2e_if.sv
// q2e channel interfaces: quaternion input, angle output, unit config.
// Depends on q2e_pkg.
`default_nettype none

interface q2e_quat_if;
  import q2e_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [QUAT_W-1:0] quat_w;
  logic signed [QUAT_W-1:0] quat_x;
  logic signed [QUAT_W-1:0] quat_y;
  logic signed [QUAT_W-1:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2e_angle_if;
  import q2e_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] roll_angle;
  logic signed [ANG_W-1:0] pitch_angle;
  logic signed [ANG_W-1:0] yaw_angle;
  logic                    pitch_clamped;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                  input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                  output ready);
endinterface

interface q2e_cfg_if;
  logic valid;
  logic ready;
  logic angle_unit;
  modport source (output valid, angle_unit, input ready);
  modport sink   (input valid, angle_unit, output ready);
endinterface

`default_nettype wire

### src/q2e_front.sv
// q2e_front: three stages of products, sums, gimbal test and 1 - sp^2.
// Depends on q2e_pkg.
`default_nettype none

module q2e_front (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [q2e_pkg::QUAT_W-1:0] quat_w,
  input  wire logic signed [q2e_pkg::QUAT_W-1:0] quat_x,
  input  wire logic signed [q2e_pkg::QUAT_W-1:0] quat_y,
  input  wire logic signed [q2e_pkg::QUAT_W-1:0] quat_z,
  output q2e_pkg::front_t                        side,
  output logic [q2e_pkg::REM_W-1:0]              rem
);
  import q2e_pkg::*;

  logic signed [PROD_W-1:0] wx, yz, xx, yy, wz, xy, zz, wy, zx;
  front_t                   s2, s2_next;
  logic [MAG_W-1:0]         mag, mag_next;
  logic signed [SUM_W-1:0]  sp_abs;

  // stage 1: pairwise products
  always_ff @(posedge clk) begin
    if (en) begin
      wx <= PROD_W'(quat_w) * PROD_W'(quat_x);
      yz <= PROD_W'(quat_y) * PROD_W'(quat_z);
      xx <= PROD_W'(quat_x) * PROD_W'(quat_x);
      yy <= PROD_W'(quat_y) * PROD_W'(quat_y);
      wz <= PROD_W'(quat_w) * PROD_W'(quat_z);
      xy <= PROD_W'(quat_x) * PROD_W'(quat_y);
      zz <= PROD_W'(quat_z) * PROD_W'(quat_z);
      wy <= PROD_W'(quat_w) * PROD_W'(quat_y);
      zx <= PROD_W'(quat_z) * PROD_W'(quat_x);
    end
  end

  // stage 2: sums, clamp test, |sp|
  always_comb begin
    s2_next.sr  = (SUM_W'(wx) + SUM_W'(yz)) <<< 1;
    s2_next.cr  = ONE_Q28 - ((SUM_W'(xx) + SUM_W'(yy)) <<< 1);
    s2_next.sy  = (SUM_W'(wz) + SUM_W'(xy)) <<< 1;
    s2_next.cy  = ONE_Q28 - ((SUM_W'(yy) + SUM_W'(zz)) <<< 1);
    s2_next.sp  = (SUM_W'(wy) - SUM_W'(zx)) <<< 1;
    s2_next.clp = (s2_next.sp >= ONE_Q28);
    s2_next.cln = (s2_next.sp <= -ONE_Q28);
    sp_abs      = s2_next.sp[SUM_W-1] ? -s2_next.sp : s2_next.sp;
    // only meaningful when not clamped, then |sp| < 2^28
    mag_next    = sp_abs[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2  <= s2_next;
      mag <= mag_next;
    end
  end

  // stage 3: 2^56 - sp^2, full-width square
  always_ff @(posedge clk) begin
    if (en) begin
      side <= s2;
      rem  <= (REM_W'(1) << REM_TOP) - (REM_W'(mag) * REM_W'(mag));
    end
  end

endmodule

`default_nettype wire

### src/q2e_isqrt.sv
// q2e_isqrt: floor square root, one result bit per pipeline stage.
// Depends on q2e_pkg; carries the front_t sums alongside.
`default_nettype none

module q2e_isqrt (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [q2e_pkg::REM_W-1:0]  rem,
  input  wire q2e_pkg::front_t            side_in,
  output logic [q2e_pkg::ROOT_W-1:0]      root,
  output q2e_pkg::front_t                 side_out
);
  import q2e_pkg::*;

  logic [REM_W-1:0] n   [ISQ_LAT+1];
  logic [REM_W-1:0] res [ISQ_LAT+1];
  front_t           sd  [ISQ_LAT+1];

  assign n[0]   = rem;
  assign res[0] = '0;
  assign sd[0]  = side_in;

  for (genvar k = 0; k < ISQ_LAT; k++) begin : g_stage
    localparam logic [REM_W-1:0] BIT = REM_W'(1) << (REM_TOP - 2 * k);
    logic [REM_W-1:0] trial;
    logic             ge;

    // restoring step: try res + bit
    always_comb begin
      trial = res[k] + BIT;
      ge    = (n[k] >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n[k+1]   <= ge ? n[k] - trial : n[k];
        res[k+1] <= ge ? (res[k] >> 1) + BIT : res[k] >> 1;
        sd[k+1]  <= sd[k];
      end
    end
  end

  assign root     = res[ISQ_LAT][ROOT_W-1:0];
  assign side_out = sd[ISQ_LAT];

endmodule

`default_nettype wire

### src/q2e_cordic.sv
// q2e_cordic: pipelined vectoring CORDIC for atan2(y, x), a quadrant
// pre-rotation stage then one stage per iteration. Depends on q2e_pkg.
`default_nettype none

module q2e_cordic #(
  parameter int STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic signed [q2e_pkg::SUM_W-1:0] y_in,
  input  wire logic signed [q2e_pkg::SUM_W-1:0] x_in,
  output logic signed [q2e_pkg::Z_W-1:0]        angle
);
  import q2e_pkg::*;

  logic signed [XY_W-1:0] x  [STEPS+1];
  logic signed [XY_W-1:0] y  [STEPS+1];
  logic signed [Z_W-1:0]  z  [STEPS+1];
  logic                   zf [STEPS+1];
  logic signed [XY_W-1:0] xe, ye;

  // stage 0: fold left half-plane, note the zero vector
  assign xe = XY_W'(x_in);
  assign ye = XY_W'(y_in);

  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (x_in == '0) && (y_in == '0);
      if (!x_in[SUM_W-1]) begin
        x[0] <= xe;
        y[0] <= ye;
        z[0] <= '0;
      end else if (!y_in[SUM_W-1]) begin
        x[0] <= ye;
        y[0] <= -xe;
        z[0] <= HALF_PI_Q28;
      end else begin
        x[0] <= -ye;
        y[0] <= xe;
        z[0] <= -HALF_PI_Q28;
      end
    end
  end

  // micro-rotations
  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    localparam logic signed [Z_W-1:0] ATAN = atan_q28(i);
    logic signed [XY_W-1:0] xs, ys;
    assign xs = x[i] >>> i;
    assign ys = y[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (!y[i][XY_W-1]) begin
          x[i+1] <= x[i] + ys;
          y[i+1] <= y[i] - xs;
          z[i+1] <= z[i] + ATAN;
        end else begin
          x[i+1] <= x[i] - ys;
          y[i+1] <= y[i] + xs;
          z[i+1] <= z[i] - ATAN;
        end
      end
    end
  end

  assign angle = zf[STEPS] ? '0 : z[STEPS];

endmodule

`default_nettype wire

### src/q2e_scale.sv
// q2e_scale: unit conversion, round half up and 16-bit saturation for the
// three angles; its second stage is the output register. Depends on q2e_pkg.
`default_nettype none

module q2e_scale (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire q2e_pkg::unit_t                 unit,
  input  wire logic signed [q2e_pkg::Z_W-1:0] roll_z,
  input  wire logic signed [q2e_pkg::Z_W-1:0] pitch_z,
  input  wire logic signed [q2e_pkg::Z_W-1:0] yaw_z,
  input  wire logic                           clamp_in,
  output logic signed [q2e_pkg::ANG_W-1:0]    roll_angle,
  output logic signed [q2e_pkg::ANG_W-1:0]    pitch_angle,
  output logic signed [q2e_pkg::ANG_W-1:0]    yaw_angle,
  output logic                                pitch_clamped
);
  import q2e_pkg::*;

  localparam int R_W = SCL_W - RND_SH;
  localparam logic signed [SCL_W-1:0] HALF = SCL_W'(1) << (RND_SH - 1);
  localparam logic signed [R_W-1:0] SAT_HI = R_W'((1 << (ANG_W - 1)) - 1);
  localparam logic signed [R_W-1:0] SAT_LO = -R_W'(1 << (ANG_W - 1));

  logic signed [SCL_W-1:0] p_roll, p_pitch, p_yaw;
  logic                    clamp_q;

  // radians map to the same shift after a 2^28 lift
  function automatic logic signed [SCL_W-1:0] lift(input logic signed [Z_W-1:0] z,
                                                   input unit_t u);
    logic signed [SCL_W-1:0] r;
    if (u == UNIT_DEG) r = SCL_W'(z) * SCL_W'(DEG64_Q16);
    else               r = SCL_W'(z) <<< RAD_SH;
    return r;
  endfunction

  function automatic logic signed [ANG_W-1:0] round_sat(input logic signed [SCL_W-1:0] p);
    logic signed [SCL_W-1:0] s;
    logic signed [R_W-1:0]   r;
    logic signed [ANG_W-1:0] o;
    s = (p + HALF) >>> RND_SH;
    r = s[R_W-1:0];
    if (r > SAT_HI)      o = SAT_HI[ANG_W-1:0];
    else if (r < SAT_LO) o = SAT_LO[ANG_W-1:0];
    else                 o = r[ANG_W-1:0];
    return o;
  endfunction

  // stage A: scale
  always_ff @(posedge clk) begin
    if (en) begin
      p_roll  <= lift(roll_z, unit);
      p_pitch <= lift(pitch_z, unit);
      p_yaw   <= lift(yaw_z, unit);
      clamp_q <= clamp_in;
    end
  end

  // stage B: round, saturate, output register
  always_ff @(posedge clk) begin
    if (en) begin
      roll_angle    <= round_sat(p_roll);
      pitch_angle   <= round_sat(p_pitch);
      yaw_angle     <= round_sat(p_yaw);
      pitch_clamped <= clamp_q;
    end
  end

endmodule

`default_nettype wire

### src/quaternion_to_euler_angles_core.sv
// quaternion_to_euler_angles_core: top level, quaternion to ZYX Euler angles.
// Depends on q2e_pkg, q2e_if, q2e_front, q2e_isqrt, q2e_cordic, q2e_scale.
//
//   channel   direction  payload
//   quat      in         quat_w, quat_x, quat_y, quat_z (signed Q1.14)
//   angles    out        roll_angle, pitch_angle, yaw_angle, pitch_clamped
//   cfg       in         angle_unit (0 radians Q3.12, 1 degrees*64)
//
// One transaction per cycle while the output is not stalled; data passes the
// front, the one-bit-per-stage square root, then the CORDIC and scale stages.
// Synchronous reset clears valid bits and the unit register.
// A stall at the output freezes the whole pipeline; quat.ready follows.
`default_nettype none

module quaternion_to_euler_angles_core #(
  parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  q2e_quat_if.sink    quat,
  q2e_angle_if.source angles,
  q2e_cfg_if.sink     cfg
);
  import q2e_pkg::*;

  localparam int CLAT = CORDIC_STEPS + 1;
  localparam int NST  = FRONT_LAT + ISQ_LAT + CLAT + SCALE_LAT;

  logic                    en;
  logic [NST-1:0]          vld;
  unit_t                   unit;
  front_t                  f_side, i_side;
  logic [REM_W-1:0]        rem;
  logic [ROOT_W-1:0]       root;
  logic signed [Z_W-1:0]   roll_z, pitch_c, yaw_z, pitch_z;
  logic                    clp_d [CLAT];
  logic                    cln_d [CLAT];

  // global advance
  assign en         = !vld[NST-1] || angles.ready;
  assign quat.ready = en;
  assign angles.valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], quat.valid};
    end
  end

  // unit register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      unit <= UNIT_RAD;
    end else if (cfg.valid) begin
      unit <= unit_t'(cfg.angle_unit);
    end
  end

  q2e_front u_front (
    .clk    (clk),
    .en     (en),
    .quat_w (quat.quat_w),
    .quat_x (quat.quat_x),
    .quat_y (quat.quat_y),
    .quat_z (quat.quat_z),
    .side   (f_side),
    .rem    (rem)
  );

  q2e_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .rem      (rem),
    .side_in  (f_side),
    .root     (root),
    .side_out (i_side)
  );

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk   (clk),
    .en    (en),
    .y_in  (i_side.sr),
    .x_in  (i_side.cr),
    .angle (roll_z)
  );

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk   (clk),
    .en    (en),
    .y_in  (i_side.sp),
    .x_in  (SUM_W'(root)),
    .angle (pitch_c)
  );

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk   (clk),
    .en    (en),
    .y_in  (i_side.sy),
    .x_in  (i_side.cy),
    .angle (yaw_z)
  );

  // gimbal flags ride alongside the CORDIC
  always_ff @(posedge clk) begin
    if (en) begin
      clp_d[0] <= i_side.clp;
      cln_d[0] <= i_side.cln;
      for (int k = 1; k < CLAT; k++) begin
        clp_d[k] <= clp_d[k-1];
        cln_d[k] <= cln_d[k-1];
      end
    end
  end

  // gimbal lock: pitch pinned to a quarter turn
  always_comb begin
    if (clp_d[CLAT-1])      pitch_z = HALF_PI_Q28;
    else if (cln_d[CLAT-1]) pitch_z = -HALF_PI_Q28;
    else                    pitch_z = pitch_c;
  end

  q2e_scale u_scale (
    .clk           (clk),
    .en            (en),
    .unit          (unit),
    .roll_z        (roll_z),
    .pitch_z       (pitch_z),
    .yaw_z         (yaw_z),
    .clamp_in      (clp_d[CLAT-1] || cln_d[CLAT-1]),
    .roll_angle    (angles.roll_angle),
    .pitch_angle   (angles.pitch_angle),
    .yaw_angle     (angles.yaw_angle),
    .pitch_clamped (angles.pitch_clamped)
  );

endmodule

`default_nettype wire
